// ----- src/shell_command_tokenizer_macros.svh -----
// Assertion macros for the shell command tokenizer checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SHELL_COMMAND_TOKENIZER_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Antecedent implies consequent in the next cycle.
`define SCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ----- src/sct_pkg.sv -----
// Shared types, codes and constants of the shell command tokenizer.
// Used by every module of the block; depends on nothing else.
package sct_pkg;

  localparam int unsigned BundleMax       = 4;
  localparam int unsigned CntW            = $clog2(BundleMax + 1);
  localparam int unsigned IdxW            = $clog2(BundleMax);
  localparam int unsigned QueueDepthDflt  = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_ENDW   = 3'd1,
    KIND_OP     = 3'd2,
    KIND_NL     = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    OP_AND_IF       = 4'd0,
    OP_AMP          = 4'd1,
    OP_OR_IF        = 4'd2,
    OP_PIPE         = 4'd3,
    OP_CASE_END     = 4'd4,
    OP_SEMI         = 4'd5,
    OP_HEREDOC      = 4'd6,
    OP_HEREDOC_TRIM = 4'd7,
    OP_DUP_IN       = 4'd8,
    OP_READ_WRITE   = 4'd9,
    OP_LESS         = 4'd10,
    OP_FORCE_OUT    = 4'd11,
    OP_APPEND       = 4'd12,
    OP_DUP_OUT      = 4'd13,
    OP_REDIR_OUT    = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_e;

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_AMP  = 3'd1,
    PEND_BAR  = 3'd2,
    PEND_SEMI = 3'd3,
    PEND_LT   = 3'd4,
    PEND_LTLT = 3'd5,
    PEND_GT   = 3'd6
  } pend_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    op_e        op_code;
    quote_e     open_quote;
    logic       line_cont;
    logic       last;
  } out_t;

  typedef struct packed {
    out_t [BundleMax-1:0] res;
    logic [CntW-1:0]      cnt;
  } bundle_t;

  typedef struct packed {
    quote_e quote;
    logic   comment;
    logic   esc;
    logic   held;
    logic   word;
    pend_e  pend;
    logic   cont;
  } state_t;

  function automatic out_t mk_res(kind_e k, logic [7:0] c, op_e op, quote_e q, logic lc);
    out_t r;
    r.kind       = k;
    r.char_out   = c;
    r.op_code    = op;
    r.open_quote = q;
    r.line_cont  = lc;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic op_e lone_op(pend_e p);
    op_e r;
    case (p)
      PEND_AMP:  r = OP_AMP;
      PEND_BAR:  r = OP_PIPE;
      PEND_SEMI: r = OP_SEMI;
      PEND_LT:   r = OP_LESS;
      PEND_LTLT: r = OP_HEREDOC;
      default:   r = OP_REDIR_OUT;
    endcase
    return r;
  endfunction

endpackage

// ----- src/sct_front.sv -----
// Front part of the tokenizer: accepts bytes, keeps the lexer state and
// packs the results of each byte into one bundle. Depends on sct_pkg.
module sct_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sct_pkg::in_t     in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output sct_pkg::bundle_t bundle_o
);
  import sct_pkg::*;

  state_t                 st_q, st_d;
  out_t    [4:0]          cand;
  logic    [4:0]          en;
  logic                   accept;
  logic                   used;
  logic    [7:0]          c;
  op_e                    op;
  quote_e                 m;
  logic    [CntW-1:0]     pos;

  assign c          = in_data_i.ch;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    st_d = st_q;
    en   = '0;
    used = 1'b0;
    op   = lone_op(st_q.pend);
    m    = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
    for (int i = 0; i < 5; i++) begin
      cand[i] = mk_res(KIND_CHAR, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
    end

    if (in_data_i.end_mark) begin
      en[2]   = (st_q.pend != PEND_NONE);
      cand[2] = mk_res(KIND_OP, CH_NONE, lone_op(st_q.pend), Q_NONE, 1'b0);
      en[3]   = st_q.word;
      cand[3] = mk_res(KIND_ENDW, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
      en[4]   = 1'b1;
      cand[4] = mk_res(KIND_STATUS, CH_NONE, OP_AND_IF, st_q.quote, st_q.held);
      st_d    = '0;
    end else begin
      // A held escaped newline becomes part of the word.
      en[0]   = st_q.held && st_q.cont;
      cand[0] = mk_res(KIND_CHAR, CH_BSLASH, OP_AND_IF, Q_NONE, 1'b0);
      en[1]   = st_q.held;
      cand[1] = mk_res(KIND_CHAR, CH_NL, OP_AND_IF, Q_NONE, 1'b0);
      st_d.held = 1'b0;
      st_d.cont = 1'b0;
      if (st_q.held) begin
        st_d.word = 1'b1;
      end

      // Operator lookahead.
      if (st_q.pend != PEND_NONE) begin
        en[2]     = 1'b1;
        st_d.pend = PEND_NONE;
        case (st_q.pend)
          PEND_AMP: begin
            if (c == CH_AMP) begin
              used = 1'b1;
              op   = OP_AND_IF;
            end
          end
          PEND_BAR: begin
            if (c == CH_BAR) begin
              used = 1'b1;
              op   = OP_OR_IF;
            end
          end
          PEND_SEMI: begin
            if (c == CH_SEMI) begin
              used = 1'b1;
              op   = OP_CASE_END;
            end
          end
          PEND_LT: begin
            if (c == CH_LT) begin
              used      = 1'b1;
              en[2]     = 1'b0;
              st_d.pend = PEND_LTLT;
            end else if (c == CH_AMP) begin
              used = 1'b1;
              op   = OP_DUP_IN;
            end else if (c == CH_GT) begin
              used = 1'b1;
              op   = OP_READ_WRITE;
            end
          end
          PEND_LTLT: begin
            if (c == CH_DASH) begin
              used = 1'b1;
              op   = OP_HEREDOC_TRIM;
            end
          end
          PEND_GT: begin
            if (c == CH_BAR) begin
              used = 1'b1;
              op   = OP_FORCE_OUT;
            end else if (c == CH_GT) begin
              used = 1'b1;
              op   = OP_APPEND;
            end else if (c == CH_AMP) begin
              used = 1'b1;
              op   = OP_DUP_OUT;
            end
          end
          default: ;
        endcase
        cand[2] = mk_res(KIND_OP, CH_NONE, op, Q_NONE, 1'b0);
      end

      if (!used) begin
        if (st_q.esc) begin
          st_d.esc = 1'b0;
          if (c == CH_NL) begin
            st_d.held = 1'b1;
            st_d.cont = (st_q.quote == Q_DOUBLE);
          end else begin
            en[3]   = (st_q.quote == Q_DOUBLE) && !(c == CH_DOLLAR || c == CH_BTICK ||
                      c == CH_DQUOTE || c == CH_BSLASH);
            cand[3] = mk_res(KIND_CHAR, CH_BSLASH, OP_AND_IF, Q_NONE, 1'b0);
            en[4]   = 1'b1;
            cand[4] = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
            st_d.word = 1'b1;
          end
        end else if (st_q.comment) begin
          if (c == CH_NL) begin
            st_d.comment = 1'b0;
            en[3]        = 1'b1;
            cand[3]      = mk_res(KIND_NL, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
          end
        end else if (c == CH_BSLASH && st_q.quote != Q_SINGLE) begin
          st_d.esc = 1'b1;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          if (st_q.quote == m) begin
            en[3]      = 1'b1;
            cand[3]    = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
            en[4]      = 1'b1;
            cand[4]    = mk_res(KIND_ENDW, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
            st_d.word  = 1'b0;
            st_d.quote = Q_NONE;
          end else if (st_q.quote == Q_NONE) begin
            en[3]      = st_d.word;
            cand[3]    = mk_res(KIND_ENDW, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
            en[4]      = 1'b1;
            cand[4]    = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
            st_d.word  = 1'b1;
            st_d.quote = m;
          end else begin
            en[3]     = 1'b1;
            cand[3]   = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
            st_d.word = 1'b1;
          end
        end else if (st_q.quote != Q_NONE) begin
          en[3]     = 1'b1;
          cand[3]   = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
          st_d.word = 1'b1;
        end else begin
          cand[3] = mk_res(KIND_ENDW, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
          case (c)
            CH_NL: begin
              en[3]     = st_d.word;
              en[4]     = 1'b1;
              cand[4]   = mk_res(KIND_NL, CH_NONE, OP_AND_IF, Q_NONE, 1'b0);
              st_d.word = 1'b0;
            end
            CH_AMP, CH_BAR, CH_SEMI, CH_LT, CH_GT: begin
              en[3]     = st_d.word;
              st_d.word = 1'b0;
              case (c)
                CH_AMP:  st_d.pend = PEND_AMP;
                CH_BAR:  st_d.pend = PEND_BAR;
                CH_SEMI: st_d.pend = PEND_SEMI;
                CH_LT:   st_d.pend = PEND_LT;
                default: st_d.pend = PEND_GT;
              endcase
            end
            CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: begin
              en[3]     = st_d.word;
              st_d.word = 1'b0;
            end
            CH_HASH: begin
              en[3]        = st_d.word;
              st_d.word    = 1'b0;
              st_d.comment = 1'b1;
            end
            default: begin
              en[3]     = 1'b1;
              cand[3]   = mk_res(KIND_CHAR, c, OP_AND_IF, Q_NONE, 1'b0);
              st_d.word = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    pos      = '0;
    bundle_o = '0;
    for (int i = 0; i < 5; i++) begin
      if (en[i] && pos < CntW'(BundleMax)) begin
        bundle_o.res[pos[IdxW-1:0]] = cand[i];
        pos = pos + 1'b1;
      end
    end
    bundle_o.cnt = pos;
  end

  assign push_o = accept && (pos != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- src/sct_fifo.sv -----
// Short queue of result bundles between the front and the back part.
// Depends on sct_pkg for the bundle type.
module sct_fifo #(
  parameter int unsigned Depth = sct_pkg::QueueDepthDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sct_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sct_pkg::bundle_t data_o
);
  import sct_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntQW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntQW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntQW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- src/sct_back.sv -----
// Back part of the tokenizer: holds one bundle and hands out its results
// one per cycle when not stalled, marking the last. Depends on sct_pkg.
module sct_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sct_pkg::bundle_t data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sct_pkg::out_t    out_data_o
);
  import sct_pkg::*;

  bundle_t          cur_q, cur_d;
  logic             valid_q, valid_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  last_idx;
  logic             take;

  assign last_idx    = IdxW'(cur_q.cnt - 1'b1);
  assign out_valid_o = valid_q;

  always_comb begin
    out_data_o      = cur_q.res[idx_q];
    out_data_o.last = (idx_q == last_idx);
  end

  always_comb begin
    take    = !valid_q || (out_ready_i && idx_q == last_idx);
    pop_o   = take && !empty_i;
    valid_d = take ? !empty_i : valid_q;
    cur_d   = pop_o ? data_i : cur_q;
    if (take) begin
      idx_d = '0;
    end else if (out_ready_i) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ----- src/shell_command_tokenizer.sv -----
// Shell command tokenizer: one command line in, one byte per item, closed
// by an end marker item; tokens out as a stream of result items.
// The input channel carries ch and end_mark; the output channel carries one
// result per item (word character, end of word, operator, newline token or
// end status) with last set on the final result caused by an input item.
// An input item with no result (whitespace, a held operator, a comment byte)
// produces nothing on the output.
// With the output side idle, the first result of an accepted item passes
// through the queue and then the back part's holding register to the output.
// Input items are taken one per cycle while the queue is not full; results
// go out one per cycle while the receiver is ready, so an item with several
// results holds the output longer. A queue of QueueDepth result bundles sits
// between front and back, so input flows until a stalled receiver fills it.
// When the receiver stalls, the shown result holds until taken and the input
// ready drops only once the queue is full.
// Reset clears the lexer state and empties the queue; the end marker also
// returns the lexer state to its reset value after its status result.
module shell_command_tokenizer #(
  parameter int unsigned QueueDepth = sct_pkg::QueueDepthDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sct_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sct_pkg::out_t out_data_o
);
  import sct_pkg::*;

  bundle_t push_bundle, pop_bundle;
  logic    push, pop, full, empty;

  sct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  sct_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_bundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_bundle)
  );

  sct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .data_i      (pop_bundle),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/sct_checker.sv -----
// Port-level checker of the shell command tokenizer and its bind.
// Depends on sct_pkg and shell_command_tokenizer_macros.svh.
`include "shell_command_tokenizer_macros.svh"

module sct_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sct_pkg::out_t out_data_o
);
  import sct_pkg::*;

  `SCT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `SCT_ASSERT_IMP(a_status_last, out_valid_o && out_data_o.kind == KIND_STATUS, out_data_o.last)
  `SCT_ASSERT_IMP(a_char_only_word, out_valid_o && out_data_o.kind != KIND_CHAR, out_data_o.char_out == CH_NONE)
  `SCT_ASSERT_IMP(a_op_code_range, out_valid_o && out_data_o.kind == KIND_OP, out_data_o.op_code <= OP_REDIR_OUT)

endmodule

bind shell_command_tokenizer sct_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
